[src/sstg_pkg.sv]
`default_nettype none

package sstg_pkg;

    // datapath word of the sine evaluation, q30 fixed point
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int Q_FRAC = 30;

    // multiplier digit and step count
    localparam int MUL_DIGIT = 8;
    localparam int MUL_ACC_W = WORD_W + MUL_DIGIT;
    localparam int MUL_STEPS = WORD_W / MUL_DIGIT;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    // divider step counter, holds up to WORD_W
    localparam int CNT_W = $clog2(WORD_W) + 1;

    // taylor series divisors k*(k-1) for k = 3, 5, ..., 13
    localparam int TERM_DIV_W = 8;
    localparam int TERM_IDX_W = 3;
    localparam logic [TERM_IDX_W-1:0] LAST_TERM = 3'd5;

    localparam logic [WORD_W-1:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [15:0] FULL_SCALE = 16'd32767;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_THETA,
        ST_THETA2,
        ST_TERM_MUL,
        ST_TERM_DIV,
        ST_SCALE,
        ST_DONE
    } state_t;

    function automatic logic [TERM_DIV_W-1:0] term_divisor(input logic [TERM_IDX_W-1:0] idx);
        logic [TERM_DIV_W-1:0] d;
        unique case (idx)
            3'd0: d = 8'd6;
            3'd1: d = 8'd20;
            3'd2: d = 8'd42;
            3'd3: d = 8'd72;
            3'd4: d = 8'd110;
            3'd5: d = 8'd156;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[src/sstg_mul.sv]
`default_nettype none

// digit serial multiplier, one 8 bit digit of b per cycle, lsb first
module sstg_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sstg_pkg::WORD_W-1:0]   a,
    input  wire logic [sstg_pkg::WORD_W-1:0]   b,
    output logic      [sstg_pkg::PROD_W-1:0]   prod,
    output logic                               done
);

    logic [sstg_pkg::WORD_W-1:0]    a_reg;
    logic [sstg_pkg::WORD_W-1:0]    hi_reg, hi_next;
    logic [sstg_pkg::WORD_W-1:0]    lo_reg, lo_next;
    logic [sstg_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           running_reg, running_next;
    logic                           done_reg, done_next;
    logic [sstg_pkg::MUL_ACC_W-1:0] partial;
    logic [sstg_pkg::MUL_ACC_W-1:0] acc_sum;

    always_comb
    begin
        partial = {{sstg_pkg::MUL_DIGIT{1'b0}}, a_reg}
                * {{sstg_pkg::WORD_W{1'b0}}, lo_reg[sstg_pkg::MUL_DIGIT-1:0]};
        acc_sum = partial + {{sstg_pkg::MUL_DIGIT{1'b0}}, hi_reg};
    end

    always_comb
    begin
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (start)
        begin
            hi_next      = '0;
            lo_next      = b;
            cnt_next     = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            // low product bits shift in from the top as b digits leave at the bottom
            hi_next  = acc_sum[sstg_pkg::MUL_ACC_W-1:sstg_pkg::MUL_DIGIT];
            lo_next  = {acc_sum[sstg_pkg::MUL_DIGIT-1:0],
                        lo_reg[sstg_pkg::WORD_W-1:sstg_pkg::MUL_DIGIT]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sstg_pkg::MUL_CNT_W'(sstg_pkg::MUL_STEPS - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign prod = {hi_reg, lo_reg};
    assign done = done_reg;

endmodule

`default_nettype wire

[src/sstg_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module sstg_div #(
    parameter int DEN_W = 18
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [DEN_W-1:0]              rem_init,
    input  wire logic [sstg_pkg::WORD_W-1:0]   num,
    input  wire logic [DEN_W-1:0]              den,
    input  wire logic [sstg_pkg::CNT_W-1:0]    steps,
    output logic      [sstg_pkg::WORD_W-1:0]   quo,
    output logic                               done
);

    logic [DEN_W-1:0]              rem_reg, rem_next;
    logic [DEN_W-1:0]              den_reg;
    logic [sstg_pkg::WORD_W-1:0]   q_reg, q_next;
    logic [sstg_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          running_reg, running_next;
    logic                          done_reg, done_next;
    logic [DEN_W:0]                trial;
    logic [DEN_W:0]                diff;
    logic                          fits;

    always_comb
    begin
        trial = {rem_reg, q_reg[sstg_pkg::WORD_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        rem_next     = rem_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (start)
        begin
            rem_next     = rem_init;
            q_next       = num;
            cnt_next     = steps;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            // remainder stays below the divisor, so it fits back in DEN_W bits
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_next   = {q_reg[sstg_pkg::WORD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == sstg_pkg::CNT_W'(1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[src/stereo_sine_tone_generator_core.sv]
`default_nettype none

// Stereo sine tone generator. Each accepted tick word with tick set yields one
// frame: a 16-bit sample of 32767*sin(angle), the same on left and right,
// where the angle is floor(phase*2^ANGLE_BITS/sample_rate) of a full turn and
// the phase steps by tone_freq modulo sample_rate. If tone_freq is not below
// sample_rate the frame is zero with config_error set and the phase holds.
// A tick word with tick clear is taken and gives nothing. A normal frame
// runs a bit-serial phase-to-angle divide, nine 8-bit digit-serial
// multiplies and six bit-serial divides by the Taylor coefficients,
// which dominate the frame time. An error frame skips the arithmetic and
// goes straight to the output side. One frame is in work at a time; a
// finished frame waits in the output register while the next tick is
// taken. Registers sample_rate (index 0) and tone_freq (index 1) may only
// be written while the block is idle; other indexes are ignored.
module stereo_sine_tone_generator_core #(
    parameter int ANGLE_BITS = 16,
    parameter int RATE_BITS  = 18
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              tick,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [15:0]                     left_sample,
    output logic signed [15:0]                     right_sample,
    output logic                                   config_error,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sstg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [RATE_BITS-1:0]              cfg_data
);

    localparam int DEN_W = (RATE_BITS > sstg_pkg::TERM_DIV_W) ? RATE_BITS
                                                              : sstg_pkg::TERM_DIV_W;
    localparam int R_W = ANGLE_BITS - 1;
    localparam logic [R_W-1:0] QUARTER = R_W'(1) << (ANGLE_BITS - 2);
    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);
    localparam logic [RATE_BITS-1:0] TONE_RESET = RATE_BITS'(1000);

    sstg_pkg::state_t state_reg, state_next;

    logic [RATE_BITS-1:0]                 rate_reg;
    logic [RATE_BITS-1:0]                 tone_reg;
    logic [RATE_BITS-1:0]                 phase_reg, phase_next;

    logic [1:0]                           quad_reg, quad_next;
    logic [sstg_pkg::WORD_W-1:0]          theta2_reg, theta2_next;
    logic [sstg_pkg::WORD_W-1:0]          term_reg, term_next;
    logic [sstg_pkg::WORD_W-1:0]          sum_reg, sum_next;
    logic [sstg_pkg::TERM_IDX_W-1:0]      kidx_reg, kidx_next;
    logic [15:0]                          res_sample_reg, res_sample_next;
    logic                                 res_err_reg, res_err_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [15:0]                          out_sample_reg;
    logic                                 out_err_reg;
    logic                                 out_load;

    logic                                 mul_start;
    logic [sstg_pkg::WORD_W-1:0]          mul_a, mul_b;
    logic [sstg_pkg::PROD_W-1:0]          mul_prod;
    logic                                 mul_done;

    logic                                 div_start;
    logic [DEN_W-1:0]                     div_rem_init, div_den;
    logic [sstg_pkg::WORD_W-1:0]          div_num, div_quo;
    logic [sstg_pkg::CNT_W-1:0]           div_steps;
    logic                                 div_done;

    logic                                 take;
    logic [RATE_BITS-1:0]                 ph_now;
    logic [RATE_BITS:0]                   ph_sum;
    logic [RATE_BITS:0]                   ph_wrap;
    logic [ANGLE_BITS-1:0]                angle;
    logic [R_W-1:0]                       rpos;
    logic [sstg_pkg::WORD_W-1:0]          mul_q30;
    logic [sstg_pkg::WORD_W-1:0]          div_term;
    logic [sstg_pkg::WORD_W-1:0]          sum_upd;
    logic [16:0]                          mag_wide;
    logic [15:0]                          mag;

    sstg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    sstg_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num      (div_num),
        .den      (div_den),
        .steps    (div_steps),
        .quo      (div_quo),
        .done     (div_done)
    );

    assign in_stall  = (state_reg != sstg_pkg::ST_IDLE);
    assign take      = in_valid && !in_stall && tick;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == sstg_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // phase wrap after a register write, and the step for the next frame
    always_comb
    begin
        ph_now  = (phase_reg >= rate_reg) ? '0 : phase_reg;
        ph_sum  = {1'b0, ph_now} + {1'b0, tone_reg};
        ph_wrap = (ph_sum >= {1'b0, rate_reg}) ? (ph_sum - {1'b0, rate_reg}) : ph_sum;
    end

    always_comb
    begin
        angle    = div_quo[ANGLE_BITS-1:0];
        rpos     = {1'b0, angle[ANGLE_BITS-3:0]};
        mul_q30  = mul_prod[sstg_pkg::Q_FRAC+sstg_pkg::WORD_W-1:sstg_pkg::Q_FRAC];
        div_term = div_quo;
        // odd terms alternate: subtract for k = 3, 7, 11, held at zero
        if (kidx_reg[0] == 1'b0)
        begin
            sum_upd = (sum_reg >= div_term) ? (sum_reg - div_term) : '0;
        end
        else
        begin
            sum_upd = sum_reg + div_term;
        end
        mag_wide = mul_prod[sstg_pkg::Q_FRAC+16:sstg_pkg::Q_FRAC];
        mag      = (mag_wide > {1'b0, sstg_pkg::FULL_SCALE}) ? sstg_pkg::FULL_SCALE
                                                             : mag_wide[15:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        quad_next       = quad_reg;
        theta2_next     = theta2_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        kidx_next       = kidx_reg;
        res_sample_next = res_sample_reg;
        res_err_next    = res_err_reg;
        mul_start       = 1'b0;
        mul_a           = term_reg;
        mul_b           = theta2_reg;
        div_start       = 1'b0;
        div_rem_init    = '0;
        div_num         = mul_q30;
        div_den         = DEN_W'(sstg_pkg::term_divisor(kidx_reg));
        div_steps       = sstg_pkg::CNT_W'(sstg_pkg::WORD_W);

        unique case (state_reg)
            sstg_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (tone_reg >= rate_reg)
                    begin
                        res_sample_next = '0;
                        res_err_next    = 1'b1;
                        state_next      = sstg_pkg::ST_DONE;
                    end
                    else
                    begin
                        phase_next   = ph_wrap[RATE_BITS-1:0];
                        div_start    = 1'b1;
                        div_rem_init = DEN_W'(ph_now);
                        div_num      = '0;
                        div_den      = DEN_W'(rate_reg);
                        div_steps    = sstg_pkg::CNT_W'(ANGLE_BITS);
                        state_next   = sstg_pkg::ST_PHASE;
                    end
                end
            end
            sstg_pkg::ST_PHASE:
            begin
                if (div_done)
                begin
                    quad_next  = angle[ANGLE_BITS-1:ANGLE_BITS-2];
                    mul_start  = 1'b1;
                    mul_a      = sstg_pkg::HALF_PI_Q30;
                    mul_b      = sstg_pkg::WORD_W'(angle[ANGLE_BITS-2] ? (QUARTER - rpos)
                                                                        : rpos);
                    state_next = sstg_pkg::ST_THETA;
                end
            end
            sstg_pkg::ST_THETA:
            begin
                if (mul_done)
                begin
                    term_next  = mul_prod[ANGLE_BITS-2+sstg_pkg::WORD_W-1:ANGLE_BITS-2];
                    sum_next   = mul_prod[ANGLE_BITS-2+sstg_pkg::WORD_W-1:ANGLE_BITS-2];
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[ANGLE_BITS-2+sstg_pkg::WORD_W-1:ANGLE_BITS-2];
                    mul_b      = mul_prod[ANGLE_BITS-2+sstg_pkg::WORD_W-1:ANGLE_BITS-2];
                    state_next = sstg_pkg::ST_THETA2;
                end
            end
            sstg_pkg::ST_THETA2:
            begin
                if (mul_done)
                begin
                    theta2_next = mul_q30;
                    kidx_next   = '0;
                    mul_start   = 1'b1;
                    mul_a       = term_reg;
                    mul_b       = mul_q30;
                    state_next  = sstg_pkg::ST_TERM_MUL;
                end
            end
            sstg_pkg::ST_TERM_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = sstg_pkg::ST_TERM_DIV;
                end
            end
            sstg_pkg::ST_TERM_DIV:
            begin
                if (div_done)
                begin
                    term_next = div_term;
                    sum_next  = sum_upd;
                    mul_start = 1'b1;
                    if (kidx_reg == sstg_pkg::LAST_TERM)
                    begin
                        mul_a      = sum_upd;
                        mul_b      = sstg_pkg::WORD_W'(sstg_pkg::FULL_SCALE);
                        state_next = sstg_pkg::ST_SCALE;
                    end
                    else
                    begin
                        kidx_next  = kidx_reg + 1'b1;
                        mul_a      = div_term;
                        mul_b      = theta2_reg;
                        state_next = sstg_pkg::ST_TERM_MUL;
                    end
                end
            end
            sstg_pkg::ST_SCALE:
            begin
                if (mul_done)
                begin
                    res_sample_next = quad_reg[1] ? (16'd0 - mag) : mag;
                    res_err_next    = 1'b0;
                    state_next      = sstg_pkg::ST_DONE;
                end
            end
            sstg_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = sstg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sstg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sstg_pkg::ST_IDLE;
            rate_reg      <= RATE_RESET;
            tone_reg      <= TONE_RESET;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sstg_pkg::CFG_SAMPLE_RATE)
                begin
                    rate_reg <= cfg_data;
                end
                else if (cfg_index == sstg_pkg::CFG_TONE_FREQ)
                begin
                    tone_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quad_reg       <= quad_next;
        theta2_reg     <= theta2_next;
        term_reg       <= term_next;
        sum_reg        <= sum_next;
        kidx_reg       <= kidx_next;
        res_sample_reg <= res_sample_next;
        res_err_reg    <= res_err_next;
        if (out_load)
        begin
            out_sample_reg <= res_sample_reg;
            out_err_reg    <= res_err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = out_sample_reg;
    assign right_sample = out_sample_reg;
    assign config_error = out_err_reg;

endmodule

`default_nettype wire

[verif/tb_stereo_sine_tone_generator_core.sv]
module tb_stereo_sine_tone_generator_core;

    localparam int ANGLE_W = 16;
    localparam int RATE_W = 18;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 1500;
    localparam int FRAME_TARGET = 1800;
    localparam int QUIET_AFTER = 1600;
    localparam bit [63:0] HALF_PI_FIX = 64'd1686629713;
    localparam bit [63:0] PEAK = 64'd32767;

    // indexes past the two registers, the block must ignore them
    localparam logic [sstg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [sstg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct packed {
        logic [15:0] left_val;
        logic [15:0] right_val;
        logic        err;
    } frame_t;

    class sine_tone_predictor;
        bit [RATE_W-1:0] rate_reg;
        bit [RATE_W-1:0] tone_reg;
        bit [RATE_W-1:0] phase_acc;
        frame_t          pending_frames[$];
        int              fails;
        int              shown;

        function new();
            rate_reg = 48000;
            tone_reg = 1000;
            phase_acc = '0;
            fails = 0;
            shown = 0;
        endfunction

        function void load_reg(logic [sstg_pkg::CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
            if (idx == sstg_pkg::CFG_SAMPLE_RATE)
                rate_reg = data;
            else if (idx == sstg_pkg::CFG_TONE_FREQ)
                tone_reg = data;
        endfunction

        // 32767*sin(pi/2 * r / quarter), q30 taylor series up to the 13th power
        function bit [15:0] quarter_mag(bit [63:0] r);
            bit [63:0] theta;
            bit [63:0] theta2;
            bit [63:0] term;
            bit [63:0] acc;
            bit [63:0] k;
            bit [63:0] mag;
            theta = (r * HALF_PI_FIX) >> (ANGLE_W - 2);
            theta2 = (theta * theta) >> sstg_pkg::Q_FRAC;
            term = theta;
            acc = theta;
            for (k = 3; k <= 13; k += 2)
            begin
                term = ((term * theta2) >> sstg_pkg::Q_FRAC) / (k * (k - 1));
                if (k[1:0] == 2'b11)
                    acc = (acc >= term) ? acc - term : 64'd0;
                else
                    acc += term;
            end
            mag = (acc * PEAK) >> sstg_pkg::Q_FRAC;
            if (mag > PEAK)
                mag = PEAK;
            return mag[15:0];
        endfunction

        function void take_tick(bit t);
            frame_t    f;
            bit [63:0] angle;
            bit [63:0] r;
            bit [63:0] nxt;
            bit [15:0] mag;
            if (!t)
                return;
            if (tone_reg >= rate_reg)
            begin
                // phase holds on a bad setting
                f = '{16'd0, 16'd0, 1'b1};
            end
            else
            begin
                if (phase_acc >= rate_reg)
                    phase_acc = '0;
                angle = (64'(phase_acc) << ANGLE_W) / 64'(rate_reg);
                r = angle & ((64'd1 << (ANGLE_W - 2)) - 64'd1);
                if (angle[ANGLE_W-2])
                    r = (64'd1 << (ANGLE_W - 2)) - r;
                mag = quarter_mag(r);
                if (angle[ANGLE_W-1])
                    mag = -mag;
                f = '{mag, mag, 1'b0};
                nxt = 64'(phase_acc) + 64'(tone_reg);
                if (nxt >= 64'(rate_reg))
                    nxt -= 64'(rate_reg);
                phase_acc = nxt[RATE_W-1:0];
            end
            pending_frames.push_back(f);
        endfunction

        function void match_frame(logic [15:0] l, logic [15:0] r, logic e);
            frame_t want;
            if (pending_frames.size() == 0)
            begin
                fails++;
                if (shown < 10)
                    $display("unexpected frame: left %h right %h err %b", l, r, e);
                shown++;
                return;
            end
            want = pending_frames.pop_front();
            if (want.left_val !== l || want.right_val !== r || want.err !== e)
            begin
                fails++;
                if (shown < 10)
                    $display("mismatch: expected %h %h err %b, got %h %h err %b",
                             want.left_val, want.right_val, want.err, l, r, e);
                shown++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            tick;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [15:0]              left_sample;
    logic signed [15:0]              right_sample;
    logic                            config_error;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sstg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [RATE_W-1:0]               cfg_data;

    sine_tone_predictor board = new();
    int frames_asked = 0;
    int hold_asks = 0;
    bit quiet_tail = 1'b0;

    stereo_sine_tone_generator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tick         (tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .config_error (config_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_tick(bit t);
        in_valid <= 1'b1;
        tick <= t;
        do @(posedge clk); while (in_stall);
        board.take_tick(t);
        frames_asked++;
        if (frames_asked >= QUIET_AFTER)
            quiet_tail = 1'b1;
    endtask

    task automatic rest(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic run_frames(int n, int odds);
        repeat (n)
        begin
            send_tick($urandom_range(0, 9) != 0);
            if (!quiet_tail && odds != 0 && $urandom_range(odds - 1) == 0)
                rest($urandom_range(1, 17));
        end
    endtask

    // wait for every expected frame, then let a possible zero-tick word finish
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [sstg_pkg::CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.load_reg(idx, data);
    endtask

    task automatic configure(int rate, int tone);
        drain();
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI, RATE_W'($urandom));
        if ($urandom_range(0, 1))
        begin
            write_reg(sstg_pkg::CFG_SAMPLE_RATE, RATE_W'(rate));
            write_reg(sstg_pkg::CFG_TONE_FREQ, RATE_W'(tone));
        end
        else
        begin
            write_reg(sstg_pkg::CFG_TONE_FREQ, RATE_W'(tone));
            write_reg(sstg_pkg::CFG_SAMPLE_RATE, RATE_W'(rate));
        end
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int cyc;
        int burst;
        int hold;
        int odds;
        int holds_done;
        cyc = 0;
        burst = 0;
        hold = 0;
        odds = 4;
        holds_done = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                board.match_frame(left_sample, right_sample, config_error);
            cyc++;
            if (cyc % 256 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: odds = 0;
                    1: odds = 4;
                    default: odds = 16;
                endcase
            end
            if (hold_asks != holds_done)
            begin
                hold = HOLD_CYCLES;
                holds_done++;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && odds != 0 && $urandom_range(odds - 1) == 0)
            begin
                burst = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int rate;
        int tone;
        int n;
        int odds;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        tick <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= sstg_pkg::CFG_SAMPLE_RATE;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, with a zero-tick word in between
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);

        drain();
        write_reg(CFG_UNUSED_LO, {RATE_W{1'b1}});
        write_reg(CFG_UNUSED_HI, RATE_W'($urandom));
        cfg_valid <= 1'b0;
        repeat (2) send_tick(1'b1);

        // quarter steps hit each quadrant boundary, then extreme and error settings
        configure(4, 1);
        repeat (5) send_tick(1'b1);
        configure(4, 4);
        send_tick(1'b1);
        configure(262143, 262143);
        send_tick(1'b1);
        configure(0, 0);
        send_tick(1'b1);
        configure(262143, 262142);
        repeat (3) send_tick(1'b1);
        // rate drops below the running phase, phase restarts
        configure(100000, 17);
        repeat (2) send_tick(1'b1);
        configure(1, 0);
        repeat (2) send_tick(1'b1);

        // long hold-off on the result side while words keep coming
        configure(48000, 3000);
        hold_asks++;
        repeat (40) send_tick(1'b1);

        while (frames_asked < FRAME_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: rate = 1;
                1: rate = $urandom_range(2, 16);
                2: rate = 262143;
                3, 4: rate = $urandom_range(0, 262143);
                default: rate = $urandom_range(8000, 96000);
            endcase
            case ($urandom_range(0, 9))
                0: tone = 0;
                1: tone = (rate > 0) ? rate - 1 : 0;
                2: tone = rate;
                3: tone = $urandom_range(0, 262143);
                default: tone = (rate > 1) ? $urandom_range(1, rate - 1) : 0;
            endcase
            case ($urandom_range(0, 2))
                0: odds = 0;
                1: odds = 3;
                default: odds = 8;
            endcase
            n = (tone >= rate) ? $urandom_range(1, 8) : $urandom_range(20, 120);
            configure(rate, tone);
            run_frames(n, odds);
        end

        drain();
        if (board.fails == 0 && board.pending_frames.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
src/sstg_pkg.sv
src/sstg_mul.sv
src/sstg_div.sv
src/stereo_sine_tone_generator_core.sv
verif/tb_stereo_sine_tone_generator_core.sv
